[design/smds_pkg.sv]
// ----------------------------------------------------------------------------
// smds_pkg
// Shared types and constants for the sensor matrix debounce scanner.
// ----------------------------------------------------------------------------
package smds_pkg;

  localparam int EVENT_DEPTH = 32;
  localparam int EV_IDX_W    = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int EV_CNT_W    = $clog2(EVENT_DEPTH + 1);

  localparam int CELLS   = 64;
  localparam int CELL_W  = 6;
  localparam int MCNT_W  = 8;
  localparam int COUNT_W = 6;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  localparam logic REG_PRESCALE  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       occ;
  } ev_t;

  typedef struct packed {
    logic valid;
    ev_t  ev;
  } cell_evt_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
  } scan_req_t;

  typedef struct packed {
    logic pop;
    logic peek;
  } ev_cmd_t;

  typedef struct packed {
    logic               hit;
    logic               full;
    logic [COUNT_W-1:0] stored;
    logic [COUNT_W-1:0] position;
  } ev_stat_t;

endpackage

[design/smds_cell_filter.sv]
// ----------------------------------------------------------------------------
// smds_cell_filter
// Mismatch counter memory, accepted board and the shared count/compare unit.
// ----------------------------------------------------------------------------
module smds_cell_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smds_pkg::scan_req_t          req,
  input  logic [smds_pkg::CELLS-1:0]   levels,
  input  logic [smds_pkg::MCNT_W-1:0]  threshold,
  output logic [smds_pkg::CELLS-1:0]   board,
  output smds_pkg::cell_evt_t          flip
);
  import smds_pkg::*;

  logic [MCNT_W-1:0] cnt_mem [CELLS];
  logic [MCNT_W-1:0] rd_data_r;
  logic [CELLS-1:0]  cnt_vld_r;
  logic [CELLS-1:0]  board_r;
  logic              proc_vld_r;
  logic [CELL_W-1:0] proc_cell_r;

  logic              seen;
  logic              held;
  logic [MCNT_W-1:0] cur;
  logic [MCNT_W-1:0] inc;
  logic              mism;
  logic              reach;
  logic [MCNT_W-1:0] wr_data;

  always_comb begin
    seen    = ~levels[proc_cell_r];
    held    = board_r[proc_cell_r];
    cur     = cnt_vld_r[proc_cell_r] ? rd_data_r : '0;
    inc     = cur + MCNT_W'(1);
    mism    = proc_vld_r && (seen != held);
    reach   = inc >= threshold;
    wr_data = reach ? '0 : inc;
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_data_r <= cnt_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mism) begin
      cnt_mem[proc_cell_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    proc_cell_r <= req.addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      board_r    <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= req.en;
      if (mism) begin
        cnt_vld_r[proc_cell_r] <= 1'b1;
        if (reach) begin
          board_r[proc_cell_r] <= seen;
        end
      end
    end
  end

  assign board        = board_r;
  assign flip.valid   = mism && reach;
  assign flip.ev.row  = proc_cell_r[5:3];
  assign flip.ev.col  = proc_cell_r[2:0];
  assign flip.ev.occ  = seen;

endmodule

[design/smds_event_buf.sv]
// ----------------------------------------------------------------------------
// smds_event_buf
// Event store with fill count, pop pointer and full flag.
// ----------------------------------------------------------------------------
module smds_event_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smds_pkg::cell_evt_t  push,
  input  smds_pkg::ev_cmd_t    cmd,
  output smds_pkg::ev_t        rd_ev,
  output smds_pkg::ev_stat_t   stat
);
  import smds_pkg::*;

  ev_t                 ev_mem [EVENT_DEPTH];
  ev_t                 rd_ev_r;
  logic [EV_CNT_W-1:0] count_r;
  logic [EV_CNT_W-1:0] pop_r;
  logic                full_r;

  logic                pop_hit;
  logic                peek_hit;
  logic                do_push;
  logic [EV_CNT_W-1:0] count_inc;
  logic [EV_CNT_W-1:0] peek_pos;
  logic [EV_IDX_W-1:0] rd_addr;

  always_comb begin
    pop_hit   = pop_r < count_r;
    peek_hit  = pop_r > EV_CNT_W'(1);
    do_push   = push.valid && !full_r && (count_r < EV_CNT_W'(EVENT_DEPTH));
    count_inc = count_r + EV_CNT_W'(1);
    peek_pos  = pop_r - EV_CNT_W'(2);
    rd_addr   = cmd.peek ? peek_pos[EV_IDX_W-1:0] : pop_r[EV_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ev_mem[count_r[EV_IDX_W-1:0]] <= push.ev;
    end
    if ((cmd.pop && pop_hit) || (cmd.peek && peek_hit)) begin
      rd_ev_r <= ev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pop_r   <= '0;
      full_r  <= 1'b0;
    end else if (cmd.pop) begin
      if (pop_hit) begin
        pop_r <= pop_r + EV_CNT_W'(1);
      end else begin
        pop_r   <= '0;
        count_r <= '0;
        full_r  <= 1'b0;
      end
    end else if (push.valid) begin
      if (do_push) begin
        count_r <= count_inc;
        if (count_inc >= EV_CNT_W'(EVENT_DEPTH)) begin
          full_r <= 1'b1;
        end
      end else if (count_r >= EV_CNT_W'(EVENT_DEPTH)) begin
        full_r <= 1'b1;
      end
    end
  end

  assign rd_ev         = rd_ev_r;
  assign stat.hit      = (cmd.pop && pop_hit) || (cmd.peek && peek_hit);
  assign stat.full     = full_r;
  assign stat.stored   = COUNT_W'(count_r);
  assign stat.position = COUNT_W'(pop_r);

  a_full_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    full_r == (count_r == EV_CNT_W'(EVENT_DEPTH)))
    else $error("full flag disagrees with event count");

  a_pop_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_r <= count_r)
    else $error("pop pointer beyond stored events");

  a_no_push_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.peek) |-> !push.valid)
    else $error("event pushed during a read request");

endmodule

[design/sensor_matrix_debounce_scanner.sv]
// ----------------------------------------------------------------------------
// sensor_matrix_debounce_scanner
// 8x8 sensor matrix debounce with event buffer, one cell per cycle.
// ----------------------------------------------------------------------------
// Sequence: a scanning tick walks the cells, then searches the rows and then
// loads the output; any other request goes straight to the row search.
// Throughput: one request at a time, the next taken the cycle after the
// result loads; the output load waits while out_valid is held unaccepted.
// Reset (rst_n low, synchronous): empty board, counters, prescaler and event
// buffer cleared; both registers return to 10.
// ----------------------------------------------------------------------------
module sensor_matrix_debounce_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [smds_pkg::CELLS-1:0]    in_sensor_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smds_pkg::CELLS-1:0]    out_board_state,
  output logic                          out_any_occupied,
  output logic [5:0]                    out_first_square,
  output logic                          out_first_found,
  output logic                          out_event_valid,
  output logic [2:0]                    out_event_row,
  output logic [2:0]                    out_event_col,
  output logic                          out_event_occupied,
  output logic                          out_buffer_full,
  output logic [smds_pkg::COUNT_W-1:0]  out_stored_count,
  output logic [smds_pkg::COUNT_W-1:0]  out_read_position
);
  import smds_pkg::*;

  localparam logic [7:0] RESET_VAL = 8'd10;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIND, S_DONE} state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic [7:0]  thr_r, thr_nxt;
  logic [7:0]  pcnt_r, pcnt_nxt;
  logic [6:0]  scan_cnt_r, scan_cnt_nxt;
  logic [2:0]  row_r, row_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [CELLS-1:0] levels_r, levels_nxt;
  logic [5:0]       sq_r, sq_nxt;
  logic             found_r, found_nxt;
  logic             ev_have_r, ev_have_nxt;

  logic [CELLS-1:0]   ob_board_r;
  logic [5:0]         ob_sq_r;
  logic               ob_found_r;
  ev_t                ob_ev_r;
  logic               ob_ev_vld_r;
  ev_stat_t           ob_stat_r;

  logic             in_fire;
  logic             load_out;
  logic [7:0]       pinc;
  logic [7:0]       row_byte;
  scan_req_t        scan_req;
  ev_cmd_t          ev_cmd;
  cell_evt_t        flip;
  logic [CELLS-1:0] board;
  ev_t              rd_ev;
  ev_stat_t         ev_stat;

  function automatic logic [2:0] low_bit(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  smds_cell_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (scan_req),
    .levels    (levels_r),
    .threshold (thr_r),
    .board     (board),
    .flip      (flip)
  );

  smds_event_buf u_evbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (flip),
    .cmd   (ev_cmd),
    .rd_ev (rd_ev),
    .stat  (ev_stat)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    thr_nxt       = thr_r;
    pcnt_nxt      = pcnt_r;
    scan_cnt_nxt  = scan_cnt_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    levels_nxt    = levels_r;
    sq_nxt        = sq_r;
    found_nxt     = found_r;
    ev_have_nxt   = ev_have_r;
    load_out      = 1'b0;
    pinc          = pcnt_r + 8'd1;
    row_byte      = board[{row_r, 3'b000} +: 8];

    scan_req.en   = (state_r == S_SCAN) && !scan_cnt_r[6];
    scan_req.addr = {scan_cnt_r[2:0], scan_cnt_r[5:3]};
    ev_cmd.pop    = in_fire && (in_kind == KIND_POP);
    ev_cmd.peek   = in_fire && (in_kind == KIND_PEEK);

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESCALE:  limit_nxt = cfg_data;
        REG_THRESHOLD: thr_nxt   = cfg_data;
        default:       limit_nxt = limit_r;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          levels_nxt  = in_sensor_levels;
          ev_have_nxt = ev_stat.hit;
          row_nxt     = 3'd0;
          state_nxt   = S_FIND;
          if (in_kind == KIND_TICK) begin
            if (pinc >= limit_r) begin
              pcnt_nxt     = 8'd0;
              scan_cnt_nxt = 7'd0;
              state_nxt    = S_SCAN;
            end else begin
              pcnt_nxt = pinc;
            end
          end
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 7'd1;
        if (scan_cnt_r[6]) begin
          row_nxt   = 3'd0;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (|row_byte) begin
          sq_nxt    = {row_r, low_bit(row_byte)};
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (row_r == 3'd7) begin
          sq_nxt    = 6'd0;
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          row_nxt = row_r + 3'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= RESET_VAL;
      thr_r       <= RESET_VAL;
      pcnt_r      <= 8'd0;
      scan_cnt_r  <= 7'd0;
      row_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      thr_r       <= thr_nxt;
      pcnt_r      <= pcnt_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    levels_r  <= levels_nxt;
    sq_r      <= sq_nxt;
    found_r   <= found_nxt;
    ev_have_r <= ev_have_nxt;
    if (load_out) begin
      ob_board_r  <= board;
      ob_sq_r     <= sq_r;
      ob_found_r  <= found_r;
      ob_ev_vld_r <= ev_have_r;
      ob_ev_r     <= ev_have_r ? rd_ev : '0;
      ob_stat_r   <= ev_stat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_board_state    = ob_board_r;
  assign out_any_occupied   = ob_found_r;
  assign out_first_square   = ob_sq_r;
  assign out_first_found    = ob_found_r;
  assign out_event_valid    = ob_ev_vld_r;
  assign out_event_row      = ob_ev_r.row;
  assign out_event_col      = ob_ev_r.col;
  assign out_event_occupied = ob_ev_r.occ;
  assign out_buffer_full    = ob_stat_r.full;
  assign out_stored_count   = ob_stat_r.stored;
  assign out_read_position  = ob_stat_r.position;

  a_first_is_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ob_found_r) |-> ob_board_r[ob_sq_r])
    else $error("first square not occupied on the board");

  a_empty_board: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ob_found_r) |-> (ob_board_r == '0))
    else $error("board not empty while no first square reported");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r <= 7'd64))
    else $error("scan counter overran the matrix");

endmodule
